// ----- rtl/core/jse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam int OCT_MAX   = 8;              // most octets one item can expand to
	localparam int OCT_IDX_W = $clog2(OCT_MAX);
	localparam int Q_DEPTH   = 4;              // entries in the front/back queue
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_LVL_W   = Q_PTR_W + 1;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6e;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// One classified item: the octets to send and the index of the final one
	typedef struct packed {
		logic [OCT_MAX-1:0][7:0] octs;
		logic [OCT_IDX_W-1:0]    last_idx;
	} jse_desc_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic               head_valid;
		logic               full;
		logic [Q_LVL_W-1:0] level;
	} jse_qstat_t;

	// Lower-case hex digit for a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		unique case (nib)
			4'h0: d = 8'h30;
			4'h1: d = 8'h31;
			4'h2: d = 8'h32;
			4'h3: d = 8'h33;
			4'h4: d = 8'h34;
			4'h5: d = 8'h35;
			4'h6: d = 8'h36;
			4'h7: d = 8'h37;
			4'h8: d = 8'h38;
			4'h9: d = 8'h39;
			4'ha: d = 8'h61;
			4'hb: d = 8'h62;
			4'hc: d = 8'h63;
			4'hd: d = 8'h64;
			4'he: d = 8'h65;
			default: d = 8'h66;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/core/jse_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_classify
// Front end: turns one string octet and its flags into the list of octets
// that the back end sends, with opening and closing quotes in place.
// ----------------------------------------------------------------------------
module jse_classify import jse_pkg::*; (
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       empty_string,
	output jse_desc_t  desc
);

	logic [OCT_MAX-1:0][7:0] body;
	logic [OCT_IDX_W-1:0]    body_n;
	logic [7:0]              code;
	logic [OCT_IDX_W-1:0]    j;
	logic [OCT_IDX_W:0]      total;

	// Escape the octet itself
	always_comb begin
		body = '0;
		code = '0;
		unique case (data_byte)
			CH_LF:   code = CH_LC_N;
			CH_CR:   code = CH_LC_R;
			CH_TAB:  code = CH_LC_T;
			CH_FF:   code = CH_LC_F;
			CH_BEL:  code = CH_LC_B;
			default: code = '0;
		endcase
		if (data_byte == CH_QUOTE || data_byte == CH_BSLASH) begin
			body[0] = CH_BSLASH;
			body[1] = data_byte;
			body_n  = OCT_IDX_W'(2);
		end else if (data_byte >= CH_SPACE) begin
			body[0] = data_byte;
			body_n  = OCT_IDX_W'(1);
		end else if (code != '0) begin
			body[0] = CH_BSLASH;
			body[1] = code;
			body_n  = OCT_IDX_W'(2);
		end else begin
			body[0] = CH_BSLASH;
			body[1] = CH_LC_U;
			body[2] = CH_ZERO;
			body[3] = CH_ZERO;
			body[4] = hex_digit(data_byte[7:4]);
			body[5] = hex_digit(data_byte[3:0]);
			body_n  = OCT_IDX_W'(6);
		end
	end

	// Place quotes around the escaped body
	always_comb begin
		desc  = '0;
		j     = '0;
		total = {1'b0, body_n} + (OCT_IDX_W+1)'(first_byte) + (OCT_IDX_W+1)'(last_byte);
		if (empty_string) begin
			desc.octs[0]  = CH_QUOTE;
			desc.octs[1]  = CH_QUOTE;
			desc.last_idx = OCT_IDX_W'(1);
		end else begin
			for (int i = 0; i < OCT_MAX; i++) begin
				j = OCT_IDX_W'(i) - OCT_IDX_W'(first_byte);
				if (first_byte && i == 0) begin
					desc.octs[i] = CH_QUOTE;
				end else if (j < body_n) begin
					desc.octs[i] = body[j];
				end else begin
					desc.octs[i] = CH_QUOTE;
				end
			end
			desc.last_idx = OCT_IDX_W'(total - 1'b1);
		end
	end

endmodule

// ----- rtl/core/jse_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module jse_queue import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  jse_desc_t  push_desc,
	input  logic       pop,
	output jse_desc_t  head_desc,
	output jse_qstat_t stat
);

	jse_desc_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_LVL_W-1:0] level_q;
	logic               do_push;
	logic               do_pop;

	assign do_push = push && (level_q != Q_LVL_W'(Q_DEPTH));
	assign do_pop  = pop && (level_q != '0);

	// Store items
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			level_q <= level_q + Q_LVL_W'(do_push) - Q_LVL_W'(do_pop);
		end
	end

	assign head_desc       = mem_q[rd_ptr_q];
	assign stat.head_valid = (level_q != '0);
	assign stat.full       = (level_q == Q_LVL_W'(Q_DEPTH));
	assign stat.level      = level_q;

endmodule

// ----- rtl/core/jse_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_emit
// Back end: walks the head item one octet per cycle into the output register
// while m_tready does not hold it, and pops it as its final octet is loaded.
// ----------------------------------------------------------------------------
module jse_emit import jse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jse_desc_t            head_desc,
	input  jse_qstat_t           stat,
	output logic                 pop,
	output logic [OCT_IDX_W-1:0] idx,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_byte
	output logic                 m_tlast
);

	logic [OCT_IDX_W-1:0] idx_q;
	logic                 m_tvalid_q;
	logic [7:0]           m_tdata_q;
	logic                 m_tlast_q;
	logic                 load;
	logic                 at_end;

	assign load   = stat.head_valid && (!m_tvalid_q || m_tready);
	assign at_end = (idx_q == head_desc.last_idx);
	assign pop    = load && at_end;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= head_desc.octs[idx_q];
			m_tlast_q <= at_end;
		end
	end

	assign idx      = idx_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- rtl/core/json_string_escaper.sv -----
`timescale 1ns / 1ps
// An accepted item passes through the queue and then the output register before its first octet shows on m_tdata.
// Throughput: one output octet per cycle while m_tready allows; an item expands to 1 to 8 octets.
// Plain printable octets thus pass at one item per cycle unless m_tready stalls.
// A four-entry queue lets the input run ahead while escaped octets drain.
// Reset (arst_n low) empties the queue and the output register at once; no clearing pass.
// ----------------------------------------------------------------------------
// json_string_escaper
// Quotes and escapes a byte stream as JSON-style string text; octet 0x07 is escaped as \b.
// ----------------------------------------------------------------------------
module json_string_escaper import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	input  logic [1:0] s_tuser,   // [0] first_byte, [1] empty_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // run_last
);

	jse_desc_t            in_desc;
	jse_desc_t            head_desc;
	jse_qstat_t           stat;
	logic                 pop;
	logic [OCT_IDX_W-1:0] idx;

	// Classify the incoming item
	jse_classify u_classify (
		.data_byte    (s_tdata),
		.first_byte   (s_tuser[0]),
		.last_byte    (s_tlast),
		.empty_string (s_tuser[1]),
		.desc         (in_desc)
	);

	assign s_tready = !stat.full;

	// Buffer classified items
	jse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_desc (in_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.stat      (stat)
	);

	// Send octets
	jse_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_desc (head_desc),
		.stat      (stat),
		.pop       (pop),
		.idx       (idx),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= Q_LVL_W'(Q_DEPTH))
		else $error("queue level beyond depth");

	a_idx_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		stat.head_valid |-> idx <= head_desc.last_idx)
		else $error("octet index past end of item");

	a_pop_only_full_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid && m_tlast)
		else $error("item popped without its final octet");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.head_valid |-> idx == '0)
		else $error("octet index left over with empty queue");
`endif

endmodule
